FILE: hdl/fuel_map_bilinear_blend_macros.svh
// Assertion macros shared by the fuel map block.
// No dependencies; include by bare file name.
`ifndef FUEL_MAP_BILINEAR_BLEND_MACROS_SVH
`define FUEL_MAP_BILINEAR_BLEND_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FMB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FMB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fmb_pkg.sv
// Package for the fuel map block: word types, codes, axis and table reset values.
// No dependencies.
package fmb_pkg;

	localparam int RPM_PTS = 8;
	localparam int THR_PTS = 8;
	localparam int PRS_PTS = 8;

	localparam logic [2:0] ACT_COMPUTE = 3'd0;
	localparam logic [2:0] ACT_WR_THR  = 3'd1;
	localparam logic [2:0] ACT_WR_PRS  = 3'd2;
	localparam logic [2:0] ACT_WR_RAX  = 3'd3;
	localparam logic [2:0] ACT_WR_TAX  = 3'd4;
	localparam logic [2:0] ACT_WR_PAX  = 3'd5;

	localparam logic [1:0] MODE_THR   = 2'd0;
	localparam logic [1:0] MODE_PRS   = 2'd1;
	localparam logic [1:0] MODE_BLEND = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] REG_MODE = 2'd0;

	localparam logic [RPM_PTS-1:0][13:0] RPM_INIT = {14'd6000, 14'd5000, 14'd4000,
		14'd3000, 14'd2000, 14'd1500, 14'd1000, 14'd600};
	localparam logic [THR_PTS-1:0][9:0] THR_INIT = {10'd1000, 10'd900, 10'd750,
		10'd600, 10'd400, 10'd200, 10'd100, 10'd0};
	localparam logic [PRS_PTS-1:0][11:0] PRS_INIT = {12'd900, 12'd800, 12'd700,
		12'd600, 12'd500, 12'd400, 12'd300, 12'd200};

	typedef struct packed {
		logic [2:0]  action;
		logic [13:0] engine_rpm;
		logic [9:0]  throttle_pos;
		logic [11:0] manifold_kpa;
		logic [8:0]  blend_weight;
		logic [2:0]  row_index;
		logic [2:0]  col_index;
		logic [15:0] write_value;
	} req_t;

	typedef struct packed {
		logic [15:0] pulse_width;
		logic        clipped;
	} rsp_t;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_SEG  = 12'b000000000010,
		ST_RD   = 12'b000000000100,
		ST_M1   = 12'b000000001000,
		ST_M2   = 12'b000000010000,
		ST_ACC  = 12'b000000100000,
		ST_DEN  = 12'b000001000000,
		ST_DCHK = 12'b000010000000,
		ST_DIV  = 12'b000100000000,
		ST_DEND = 12'b001000000000,
		ST_BL   = 12'b010000000000,
		ST_FIN  = 12'b100000000000
	} state_t;

	// Reset value of a table cell; sel high picks the pressure table.
	function automatic logic [15:0] cell_init(input logic sel, input logic [2:0] r,
		input logic [2:0] c);
		logic [15:0] v;
		if (sel) v = 16'd300 + 16'd50 * {13'd0, r} + 16'd100 * {13'd0, c};
		else     v = 16'd400 + 16'd100 * {13'd0, r} + 16'd100 * {13'd0, c};
		return v;
	endfunction

	// First segment with a[i] <= v < a[i+1]; last one also takes v == a[n-1].
	function automatic logic [2:0] find_seg(input logic [RPM_PTS-1:0][13:0] ax,
		input logic [13:0] v);
		logic [2:0] seg;
		logic       hit;
		seg = 3'd0;
		hit = 1'b0;
		for (int i = 0; i < RPM_PTS - 1; i++) begin
			if (!hit && v >= ax[i] && (v < ax[i+1] || (i == RPM_PTS - 2 && v == ax[i+1]))) begin
				seg = 3'(i);
				hit = 1'b1;
			end
		end
		return seg;
	endfunction

endpackage

FILE: hdl/fuel_map_bilinear_blend.sv
// Fuel map lookup: two 8x8 tables, bilinear interpolation, blend and saturation.
// Depends on fmb_pkg and fuel_map_bilinear_blend_macros.svh.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+--------------------------------
//  req     | in  | req_valid/req_ready  | fmb_pkg::req_t (action, operands)
//  rsp     | out | rsp_valid/rsp_ready  | fmb_pkg::rsp_t (pulse_width, clipped)
//  apb     | in  | psel/penable/pwrite  | mode register at byte 0
//
// A write word: the store updates on accept, and a zero result
// is loaded into the output register at the same edge.
// A compute word runs, per table, a segment state, four corners each through
// read, multiply, multiply and accumulate, a product and a check state, 44
// divider steps and a store state (both skipped when the denominator is zero),
// then the blend states and a final state that waits for a free output. The
// single 28x17 multiplier is shared, and the divider is one-bit-per-cycle.
// req_ready is low while a compute word is in flight or a result is stalled.
// No clearing pass after reset: table cells carry valid bits.
`include "fuel_map_bilinear_blend_macros.svh"

module fuel_map_bilinear_blend (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fmb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fmb_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import fmb_pkg::*;

	localparam int DIV_STEPS = 44;

	state_t state_q;
	logic [1:0] mode_q;
	req_t req_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [RPM_PTS-1:0][13:0] rpm_ax_q;
	logic [THR_PTS-1:0][9:0]  thr_ax_q;
	logic [PRS_PTS-1:0][11:0] prs_ax_q;

	// Cell store: both tables, address {table, row, col}.
	logic [15:0] tbl_mem [128];
	logic [127:0] tbl_vld_q;
	logic [15:0] rdata_q;
	logic        rvld_q;
	logic [6:0]  raddr_q;

	logic        tsel_q;   // 0 throttle table, 1 pressure table
	logic [2:0]  seg_i_q, seg_j_q;
	logic [1:0]  corner_q;
	logic signed [14:0] dx1_q, dx2_q, dxd_q;
	logic signed [12:0] dy1_q, dy2_q, dyd_q;
	logic [15:0] q_q, q11_q;
	logic signed [44:0] prod_q, acc_q;
	logic signed [44:0] ta_q, tp_q;
	logic signed [55:0] blend_q;
	logic [2:0]  bl_cnt_q;
	logic [43:0] dn_q;
	logic [26:0] rem_q;
	logic [25:0] dd_q;
	logic        dneg_q;
	logic [5:0]  dcnt_q;

	logic accept, compute_acc, out_free, apb_wr, rsp_set;
	assign accept      = req_valid && req_ready;
	assign compute_acc = accept && req.action == ACT_COMPUTE;
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign req_ready   = state_q == ST_IDLE && out_free;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;
	assign pready      = 1'b1;
	assign prdata      = {30'd0, mode_q};
	assign apb_wr      = psel && penable && pwrite && paddr == REG_MODE;
	// Load a result word: a write word on accept, a compute word at the end.
	assign rsp_set     = (accept && !compute_acc) || (state_q == ST_FIN && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_BLEND;
		else if (apb_wr) mode_q <= pwdata[1:0];
	end

	// Segment search and distances for the table in work.
	logic [RPM_PTS-1:0][13:0] yax;
	logic [13:0] yval;
	logic [2:0]  si, sj;
	always_comb begin
		for (int k = 0; k < RPM_PTS; k++)
			yax[k] = tsel_q ? {2'd0, prs_ax_q[k]} : {4'd0, thr_ax_q[k]};
		yval = tsel_q ? {2'd0, req_q.manifold_kpa} : {4'd0, req_q.throttle_pos};
		si   = find_seg(rpm_ax_q, req_q.engine_rpm);
		sj   = find_seg(yax, yval);
	end

	// Shared multiplier, operands picked by the sequencer.
	logic signed [27:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [44:0] mul_p;
	logic signed [9:0]  wa, wp;
	always_comb begin
		case (mode_q)
			MODE_THR:   begin wa = 10'sd256; wp = 10'sd0; end
			MODE_PRS:   begin wa = 10'sd0;   wp = 10'sd256; end
			default:    begin
				wa = 10'sd256 - $signed({1'b0, req_q.blend_weight});
				wp = $signed({1'b0, req_q.blend_weight});
			end
		endcase
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin
				mul_a = 28'(corner_q[0] ? dx1_q : dx2_q);
				mul_b = 17'(corner_q[1] ? dy1_q : dy2_q);
			end
			ST_M2: begin
				mul_a = prod_q[27:0];
				mul_b = $signed({1'b0, q_q});
			end
			ST_DEN: begin
				mul_a = 28'(dxd_q);
				mul_b = 17'(dyd_q);
			end
			ST_BL: begin
				// Low halves are unsigned, high halves carry the sign.
				case (bl_cnt_q)
					3'd0:    mul_a = $signed({6'd0, ta_q[21:0]});
					3'd1:    mul_a = 28'($signed(ta_q[44:22]));
					3'd2:    mul_a = $signed({6'd0, tp_q[21:0]});
					default: mul_a = 28'($signed(tp_q[44:22]));
				endcase
				mul_b = 17'((bl_cnt_q < 3'd2) ? wa : wp);
			end
			default: ;
		endcase
		mul_p = 45'(mul_a * mul_b);
	end

	logic [15:0] qval;
	assign qval = rvld_q ? rdata_q : cell_init(raddr_q[6], raddr_q[5:3], raddr_q[2:0]);

	// Divider step and sign handling.
	logic [26:0] r2;
	logic        qbit;
	logic signed [44:0] tquot;
	assign r2    = {rem_q[25:0], dn_q[43]};
	assign qbit  = r2 >= {1'b0, dd_q};
	assign tquot = dneg_q ? -$signed({1'b0, dn_q}) : $signed({1'b0, dn_q});

	// Final rounding toward zero and saturation; mode none gives a zero result.
	logic signed [55:0] badj;
	logic signed [47:0] bres;
	logic [15:0] fin_pw;
	logic        fin_clip;
	always_comb begin
		badj = blend_q + (blend_q[55] ? 56'sd255 : 56'sd0);
		bres = 48'(badj >>> 8);
		fin_pw = bres[15:0];
		fin_clip = 1'b0;
		if (bres < 0) begin
			fin_pw = 16'd0;
			fin_clip = 1'b1;
		end else if (bres > 48'sd65535) begin
			fin_pw = 16'hFFFF;
			fin_clip = 1'b1;
		end
		if (mode_q == MODE_NONE) begin
			fin_pw = 16'd0;
			fin_clip = 1'b0;
		end
	end

	logic [43:0] nmag;
	logic [44:0] dfull;
	assign nmag  = acc_q[44] ? 44'(-acc_q) : acc_q[43:0];
	assign dfull = prod_q[44] ? 45'(-prod_q) : prod_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			tsel_q      <= 1'b0;
			corner_q    <= 2'd0;
			bl_cnt_q    <= 3'd0;
			dcnt_q      <= 6'd0;
			rpm_ax_q    <= RPM_INIT;
			thr_ax_q    <= THR_INIT;
			prs_ax_q    <= PRS_INIT;
		end else begin
			if (rsp_set) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.action == ACT_COMPUTE) begin
							tsel_q  <= 1'b0;
							state_q <= ST_SEG;
						end else begin
							case (req.action)
								ACT_WR_RAX: rpm_ax_q[req.col_index] <= req.write_value[13:0];
								ACT_WR_TAX: thr_ax_q[req.col_index] <= req.write_value[9:0];
								ACT_WR_PAX: prs_ax_q[req.col_index] <= req.write_value[11:0];
								default: ;
							endcase
						end
					end
				end
				ST_SEG: begin
					corner_q <= 2'd0;
					state_q  <= ST_RD;
				end
				ST_RD:  state_q <= ST_M1;
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= ST_ACC;
				ST_ACC: begin
					if (corner_q == 2'd3) state_q <= ST_DEN;
					else begin
						corner_q <= corner_q + 2'd1;
						state_q  <= ST_RD;
					end
				end
				ST_DEN: state_q <= ST_DCHK;
				ST_DCHK: begin
					dcnt_q <= 6'd0;
					if (prod_q == 0) begin
						tsel_q  <= 1'b1;
						state_q <= tsel_q ? ST_BL : ST_SEG;
					end else state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(DIV_STEPS - 1)) state_q <= ST_DEND;
				end
				ST_DEND: begin
					tsel_q  <= 1'b1;
					state_q <= tsel_q ? ST_BL : ST_SEG;
				end
				ST_BL: begin
					if (bl_cnt_q == 3'd4) begin
						bl_cnt_q <= 3'd0;
						state_q  <= ST_FIN;
					end else bl_cnt_q <= bl_cnt_q + 3'd1;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q <= req;
					if (!compute_acc) rsp_q <= '0;
				end
			end
			ST_SEG: begin
				seg_i_q <= si;
				seg_j_q <= sj;
				dx1_q <= $signed({1'b0, req_q.engine_rpm}) - $signed({1'b0, rpm_ax_q[si]});
				dx2_q <= $signed({1'b0, rpm_ax_q[si + 3'd1]}) - $signed({1'b0, req_q.engine_rpm});
				dxd_q <= $signed({1'b0, rpm_ax_q[si + 3'd1]}) - $signed({1'b0, rpm_ax_q[si]});
				dy1_q <= 13'($signed({1'b0, yval}) - $signed({1'b0, yax[sj]}));
				dy2_q <= 13'($signed({1'b0, yax[sj + 3'd1]}) - $signed({1'b0, yval}));
				dyd_q <= 13'($signed({1'b0, yax[sj + 3'd1]}) - $signed({1'b0, yax[sj]}));
				acc_q <= '0;
			end
			ST_M1: begin
				prod_q <= mul_p;
				q_q    <= qval;
				if (corner_q == 2'd0) q11_q <= qval;
			end
			ST_M2:  prod_q <= mul_p;
			ST_ACC: acc_q  <= acc_q + prod_q;
			ST_DEN: prod_q <= mul_p;
			ST_DCHK: begin
				dn_q   <= nmag;
				dd_q   <= dfull[25:0];
				rem_q  <= '0;
				dneg_q <= acc_q[44] ^ prod_q[44];
				if (prod_q == 0) begin
					if (tsel_q) tp_q <= $signed({29'd0, q11_q});
					else        ta_q <= $signed({29'd0, q11_q});
				end
			end
			ST_DIV: begin
				rem_q <= qbit ? r2 - {1'b0, dd_q} : r2;
				dn_q  <= {dn_q[42:0], qbit};
			end
			ST_DEND: begin
				if (tsel_q) tp_q <= tquot;
				else        ta_q <= tquot;
			end
			ST_BL: begin
				prod_q <= mul_p;
				case (bl_cnt_q)
					3'd0: ;
					3'd1: blend_q <= 56'(prod_q);
					3'd3: blend_q <= blend_q + 56'(prod_q);
					default: blend_q <= blend_q + (56'(prod_q) <<< 22);
				endcase
			end
			ST_FIN: begin
				if (out_free) rsp_q <= '{pulse_width: fin_pw, clipped: fin_clip};
			end
			default: ;
		endcase
	end

	// Cell store: write on accept of a cell write, registered read in ST_RD.
	logic [6:0] waddr, rdaddr;
	logic       cell_wr;
	assign cell_wr = accept && (req.action == ACT_WR_THR || req.action == ACT_WR_PRS);
	assign waddr   = {req.action == ACT_WR_PRS, req.row_index, req.col_index};
	assign rdaddr  = {tsel_q, seg_i_q + {2'd0, corner_q[0]}, seg_j_q + {2'd0, corner_q[1]}};

	always_ff @(posedge clk) begin
		if (cell_wr) tbl_mem[waddr] <= req.write_value;
		if (state_q == ST_RD) begin
			rdata_q <= tbl_mem[rdaddr];
			raddr_q <= rdaddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (cell_wr) tbl_vld_q[waddr] <= 1'b1;
			if (state_q == ST_RD) rvld_q <= tbl_vld_q[rdaddr];
		end
	end

	`FMB_ASSERT_NOW(a_ready_idle, req_ready, state_q == ST_IDLE && out_free, "ready while busy")
	`FMB_ASSERT_NEXT(a_write_zero, accept && req.action != ACT_COMPUTE,
		rsp_valid && rsp.pulse_width == 16'd0 && !rsp.clipped, "write word result not zero")
	`FMB_ASSERT_NEXT(a_compute_busy, compute_acc, state_q == ST_SEG && !req_ready,
		"compute word did not start")
	`FMB_ASSERT_NOW(a_div_bound, state_q == ST_DIV, dcnt_q < 6'(DIV_STEPS),
		"divider ran past its step count")

endmodule

FILE: bench/fuel_map_bilinear_blend_test.sv
// Self-checking bench for the fuel map block: predicts each result word from a
// bit-exact model of the tables, axes and mode register, and compares on output.
// Depends on fmb_pkg and the fuel_map_bilinear_blend RTL.
`timescale 1ns / 1ps

module fuel_map_bilinear_blend_test;
	import fmb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the block's state.
	logic [15:0] thr_tbl [0:7][0:7];
	logic [15:0] prs_tbl [0:7][0:7];
	logic [13:0] rpm_ax  [0:7];
	logic [9:0]  thr_ax  [0:7];
	logic [11:0] prs_ax  [0:7];
	logic [1:0]  cur_mode;

	rsp_t pending_pw[$];
	int   error_count;
	int   idle_cycles;
	int   stall_left;
	bit   calm;   // no idling in the last part of the run

	fuel_map_bilinear_blend DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Reset the shadow state to the block's power-up contents.
	task automatic shadow_reset();
		for (int r = 0; r < 8; r++) begin
			rpm_ax[r] = RPM_INIT[r];
			thr_ax[r] = THR_INIT[r];
			prs_ax[r] = PRS_INIT[r];
			for (int c = 0; c < 8; c++) begin
				thr_tbl[r][c] = 16'(400 + 100 * r + 100 * c);
				prs_tbl[r][c] = 16'(300 + 50 * r + 100 * c);
			end
		end
		cur_mode = MODE_BLEND;
	endtask

	function automatic int seg_of(input longint a [0:7], input longint v);
		for (int i = 0; i < 7; i++)
			if (v >= a[i] && (v < a[i+1] || (i == 6 && v == a[i+1])))
				return i;
		return 0;
	endfunction

	// Bilinear lookup in one table; sel high picks the pressure table.
	function automatic longint table_value(input bit sel, input longint x, input longint y);
		longint xa [0:7];
		longint ya [0:7];
		longint x1, x2, y1, y2, q11, q12, q21, q22, den, num;
		int i, j;
		for (int k = 0; k < 8; k++) begin
			xa[k] = rpm_ax[k];
			ya[k] = sel ? longint'(prs_ax[k]) : longint'(thr_ax[k]);
		end
		i = seg_of(xa, x);
		j = seg_of(ya, y);
		x1 = xa[i]; x2 = xa[i+1]; y1 = ya[j]; y2 = ya[j+1];
		q11 = sel ? prs_tbl[i][j]     : thr_tbl[i][j];
		q12 = sel ? prs_tbl[i][j+1]   : thr_tbl[i][j+1];
		q21 = sel ? prs_tbl[i+1][j]   : thr_tbl[i+1][j];
		q22 = sel ? prs_tbl[i+1][j+1] : thr_tbl[i+1][j+1];
		den = (x2 - x1) * (y2 - y1);
		if (den == 0)
			return q11;
		num = q11 * (x2 - x) * (y2 - y) + q21 * (x - x1) * (y2 - y)
			+ q12 * (x2 - x) * (y - y1) + q22 * (x - x1) * (y - y1);
		return num / den;   // SV division truncates toward zero
	endfunction

	// Apply one word to the shadow state and return the pulse width it yields.
	function automatic rsp_t predict_pulse(input req_t w);
		longint res;
		rsp_t   o;
		res = 0;
		o = '0;
		case (w.action)
			ACT_COMPUTE: begin
				if (cur_mode == MODE_THR)
					res = table_value(0, w.engine_rpm, w.throttle_pos);
				else if (cur_mode == MODE_PRS)
					res = table_value(1, w.engine_rpm, w.manifold_kpa);
				else if (cur_mode == MODE_BLEND)
					res = (table_value(0, w.engine_rpm, w.throttle_pos)
						* (256 - longint'(w.blend_weight))
						+ table_value(1, w.engine_rpm, w.manifold_kpa)
						* longint'(w.blend_weight)) / 256;
				if (res < 0) begin
					res = 0;
					o.clipped = 1'b1;
				end
				if (res > 65535) begin
					res = 65535;
					o.clipped = 1'b1;
				end
				o.pulse_width = 16'(res);
			end
			ACT_WR_THR: thr_tbl[w.row_index][w.col_index] = w.write_value;
			ACT_WR_PRS: prs_tbl[w.row_index][w.col_index] = w.write_value;
			ACT_WR_RAX: rpm_ax[w.col_index] = w.write_value[13:0];
			ACT_WR_TAX: thr_ax[w.col_index] = w.write_value[9:0];
			ACT_WR_PAX: prs_ax[w.col_index] = w.write_value[11:0];
			default: ;
		endcase
		return o;
	endfunction

	// Send one word: optional gap first, then hold valid until accepted.
	// Valid stays high after accept; the next send or drain updates or drops it.
	task automatic send_word(input req_t w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_pw.push_back(predict_pulse(w));
	endtask

	// Drop valid, then wait until every expected word has arrived, plus margin.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_pw.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Write the mode register over APB; only called while the block is idle.
	task automatic write_mode(input logic [1:0] m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_MODE;
		pwdata  <= {30'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_mode = m;
	endtask

	function automatic req_t compute_word(input int rpm, input int tps, input int kpa,
		input int wt);
		req_t w;
		w = '0;
		w.action       = ACT_COMPUTE;
		w.engine_rpm   = 14'(rpm);
		w.throttle_pos = 10'(tps);
		w.manifold_kpa = 12'(kpa);
		w.blend_weight = 9'(wt);
		w.row_index    = 3'($urandom);
		w.col_index    = 3'($urandom);
		w.write_value  = 16'($urandom);
		return w;
	endfunction

	function automatic req_t write_word(input logic [2:0] act, input int row, input int col,
		input int val);
		req_t w;
		w = req_t'({$urandom, $urandom});
		w.action      = act;
		w.row_index   = 3'(row);
		w.col_index   = 3'(col);
		w.write_value = 16'(val);
		return w;
	endfunction

	function automatic req_t random_word();
		req_t w;
		int   k;
		w = req_t'({$urandom, $urandom});
		k = $urandom_range(0, 99);
		// Mostly computes inside the ranges, some writes and raw noise.
		if (k < 65) begin
			w = compute_word($urandom_range(0, 16383), $urandom_range(0, 1000),
				$urandom_range(0, 2550), $urandom_range(0, 256));
			if ($urandom_range(0, 9) == 0)
				w.engine_rpm = 14'($urandom);
			if ($urandom_range(0, 9) == 0)
				w.blend_weight = 9'($urandom);
		end else if (k < 80) begin
			w.action = $urandom_range(0, 1) ? ACT_WR_THR : ACT_WR_PRS;
			w.write_value = 16'($urandom_range(0, 3000));
			if ($urandom_range(0, 7) == 0)
				w.write_value = 16'($urandom);
		end else if (k < 90) begin
			w.action = 3'($urandom_range(3, 5));
		end else begin
			w.action = 3'($urandom);
		end
		return w;
	endfunction

	// Rewrite one axis as a random non-decreasing sequence, bounded by its width.
	task automatic rewrite_axis(input logic [2:0] act, input int span);
		int v;
		v = $urandom_range(0, span / 16);
		for (int c = 0; c < 8; c++) begin
			send_word(write_word(act, 0, c, v));
			v = v + $urandom_range(0, span / 8);
			if (v > span) v = span;
		end
	endtask

	task automatic test_reset_tables();
		send_word(compute_word(0, 0, 0, 0));
		send_word(compute_word(600, 0, 200, 128));
		send_word(compute_word(6000, 1000, 900, 256));
		send_word(compute_word(16383, 1023, 4095, 511));
		send_word(compute_word(2500, 500, 550, 64));
		send_word(compute_word(1500, 400, 400, 300));
		drain();
	endtask

	task automatic test_modes();
		for (int m = 0; m < 4; m++) begin
			write_mode(2'(m));
			send_word(compute_word(3456, 333, 777, 100));
			send_word(compute_word(100, 1000, 2550, 256));
			drain();
		end
		write_mode(MODE_BLEND);
	endtask

	task automatic test_writes();
		// Writes to the far corner cells and extrapolated computes, then a flat axis for a zero denominator.
		send_word(write_word(ACT_WR_THR, 7, 7, 65535));
		send_word(write_word(ACT_WR_PRS, 7, 7, 65535));
		send_word(compute_word(16383, 1023, 4095, 128));
		send_word(write_word(ACT_WR_THR, 0, 0, 0));
		send_word(compute_word(16383, 0, 0, 0));
		send_word(write_word(ACT_WR_RAX, 0, 1, 600));
		send_word(write_word(ACT_WR_TAX, 0, 1, 65535));
		send_word(write_word(ACT_WR_PAX, 0, 1, 65535));
		send_word(compute_word(600, 0, 200, 128));
		send_word(compute_word(100, 0, 200, 128));
		send_word(write_word(3'd6, 0, 0, 1));
		send_word(write_word(3'd7, 0, 0, 1));
		drain();
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 149) begin
				drain();
				write_mode(2'($urandom_range(0, 3)));
				rewrite_axis(ACT_WR_RAX, 16383);
				rewrite_axis(ACT_WR_TAX, 1023);
				rewrite_axis(ACT_WR_PAX, 4095);
			end
			if (n > count - 60)
				calm = 1'b1;
			send_word(random_word());
		end
		drain();
	endtask

	// Stall the result side in bursts of random length; none in the final stretch.
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			rsp_ready  <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= (stall_left == 1);
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 15);
			rsp_ready  <= 1'b0;
		end else
			rsp_ready <= 1'b1;
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_pw.size() == 0) begin
				$display("%0t: unexpected word %h", $time, rsp);
				error_count++;
			end else begin
				rsp_t exp_w;
				exp_w = pending_pw.pop_front();
				if (rsp.pulse_width !== exp_w.pulse_width)
					$display("%0t: pulse_width expected %0d actual %0d",
						$time, exp_w.pulse_width, rsp.pulse_width);
				if (rsp.clipped !== exp_w.clipped)
					$display("%0t: clipped expected %0b actual %0b",
						$time, exp_w.clipped, rsp.clipped);
				if (rsp !== exp_w)
					error_count++;
			end
		end
	end

	// Watchdog: count cycles with no handshake on any channel.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		stall_left  = 0;
		calm        = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b1;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		shadow_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_tables();
		test_modes();
		test_writes();
		test_random(500);
		if (error_count == 0 && pending_pw.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/fmb_pkg.sv
hdl/fuel_map_bilinear_blend.sv
bench/fuel_map_bilinear_blend_test.sv
